### src/mtlc_pkg.sv
// mtlc_pkg: shared types and constants of the label cleanup block
// word layouts of the item, result and internal command queues
// no dependencies
`default_nettype none

package mtlc_pkg;

	localparam int OP_BITS     = 2;
	localparam int LABEL_BITS  = 8;
	localparam int TISSUE_BITS = 3;

	// largest table that the field widths can ever reach
	localparam int MAX_ROWS    = 2 ** LABEL_BITS;
	localparam int MAX_TISSUES = 2 ** TISSUE_BITS;

	typedef enum logic [OP_BITS-1:0] {
		OP_VOTE    = 2'd0,
		OP_RESOLVE = 2'd1,
		OP_APPLY   = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef struct packed {
		logic [OP_BITS-1:0]     operation;
		logic [LABEL_BITS-1:0]  atlas_label;
		logic [TISSUE_BITS-1:0] tissue_class;
	} item_t;

	typedef struct packed {
		logic [LABEL_BITS-1:0] label;
		logic                  erased;
	} result_t;

	// classified command handed from the front to the back
	typedef struct packed {
		op_t                    kind;
		logic                   hit;    // nonzero region inside the table
		logic [LABEL_BITS-1:0]  label;
		logic [TISSUE_BITS-1:0] tissue;
	} cmd_t;

endpackage

`default_nettype wire

### src/mtlc_ram.sv
// mtlc_ram: generic single write port, single read port memory
// read data is registered; no dependencies
`default_nettype none

module mtlc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### src/mtlc_fifo.sv
// mtlc_fifo: two-word queue used between front and back and on the result side
// words are flat vectors; no dependencies
`default_nettype none

module mtlc_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

### src/mtlc_front.sv
// mtlc_front: takes input words and turns them into back-end commands
// drops votes for background labels and votes that fall outside the table; uses mtlc_pkg
`default_nettype none

module mtlc_front #(
	parameter int REGION_LABELS  = 256,
	parameter int TISSUE_CLASSES = 8
) (
	input  wire mtlc_pkg::item_t item,
	input  wire logic            push,
	output logic                 full,
	input  wire logic            init_busy,
	input  wire logic            cmd_full,
	output logic                 cmd_push,
	output mtlc_pkg::cmd_t       cmd
);

	logic region_ok;
	logic tissue_ok;
	logic keep;

	always_comb begin
		region_ok = (item.atlas_label != '0) && (32'(item.atlas_label) < REGION_LABELS);
		tissue_ok = 32'(item.tissue_class) < TISSUE_CLASSES;
		unique case (mtlc_pkg::op_t'(item.operation))
			mtlc_pkg::OP_VOTE: keep = region_ok && tissue_ok;
			default:           keep = 1'b1;
		endcase
	end

	// nothing enters while the vote memory is being swept after reset
	assign full = cmd_full || init_busy;

	assign cmd_push   = push && !full && keep;
	assign cmd.kind   = mtlc_pkg::op_t'(item.operation);
	assign cmd.hit    = region_ok;
	assign cmd.label  = item.atlas_label;
	assign cmd.tissue = item.tissue_class;

endmodule

`default_nettype wire

### src/mtlc_back.sv
// mtlc_back: carries out commands against the vote and majority memories
// sequencer for vote update, apply lookup, resolve scan and clearing sweep
// uses mtlc_pkg and mtlc_ram
`default_nettype none

module mtlc_back #(
	parameter int REGION_LABELS  = 256,
	parameter int TISSUE_CLASSES = 8,
	parameter int VOTE_BITS      = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mtlc_pkg::cmd_t    cmd,
	input  wire logic              cmd_empty,
	output logic                   cmd_pop,
	input  wire logic              res_full,
	output logic                   res_push,
	output mtlc_pkg::result_t      res_data,
	output logic                   init_busy
);

	// only labels and tissues the fields can carry ever get votes
	localparam int ROWS   = (REGION_LABELS > mtlc_pkg::MAX_ROWS) ?
		mtlc_pkg::MAX_ROWS : REGION_LABELS;
	localparam int TCLS   = (TISSUE_CLASSES > mtlc_pkg::MAX_TISSUES) ?
		mtlc_pkg::MAX_TISSUES : TISSUE_CLASSES;
	localparam int RB     = $clog2(ROWS);
	localparam int TB     = $clog2(TCLS);
	localparam int VDEPTH = ROWS * (2 ** TB);
	localparam int VAB    = RB + TB;
	localparam int TW     = mtlc_pkg::TISSUE_BITS;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_VOTE    = 5'b00010,
		ST_APPLY   = 5'b00100,
		ST_RESOLVE = 5'b01000,
		ST_CLEAR   = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	logic [VAB-1:0]       addr_q, addr_d;
	logic [VAB-1:0]       rd_addr_q, rd_addr_d;
	logic                 rd_vld_q, rd_vld_d;
	logic                 rs_end_q, rs_end_d;
	logic                 resolved_q, resolved_d;
	logic                 init_q, init_d;
	logic [VOTE_BITS-1:0] best_q, best_d;
	logic [TB-1:0]        best_idx_q, best_idx_d;
	mtlc_pkg::cmd_t       cmd_q, cmd_d;

	logic                 v_we;
	logic [VAB-1:0]       v_waddr;
	logic [VOTE_BITS-1:0] v_wdata;
	logic [VAB-1:0]       v_raddr;
	logic [VOTE_BITS-1:0] v_rdata;
	logic                 m_we;
	logic [RB-1:0]        m_waddr;
	logic [TW-1:0]        m_wdata;
	logic [RB-1:0]        m_raddr;
	logic [TW-1:0]        m_rdata;

	logic [TB-1:0]        rd_t;
	logic [VOTE_BITS-1:0] cur_best;
	logic [TB-1:0]        cur_idx;
	logic [TW-1:0]        maj;
	logic                 mismatch;

	mtlc_ram #(
		.WIDTH(VOTE_BITS),
		.DEPTH(VDEPTH)
	) u_vote_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(v_wdata),
		.raddr(v_raddr),
		.rdata(v_rdata)
	);

	mtlc_ram #(
		.WIDTH(TW),
		.DEPTH(ROWS)
	) u_major_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	// running maximum over one row, ties stay with the lower tissue
	always_comb begin
		rd_t = rd_addr_q[TB-1:0];
		if (rd_t == '0) begin
			cur_best = v_rdata;
			cur_idx  = '0;
		end else if (v_rdata > best_q) begin
			cur_best = v_rdata;
			cur_idx  = rd_t;
		end else begin
			cur_best = best_q;
			cur_idx  = best_idx_q;
		end
	end

	// every row is written by a resolve, so one flag stands for the reset value
	assign maj      = resolved_q ? m_rdata : '0;
	assign mismatch = (cmd_q.tissue != maj);

	always_comb begin
		state_d    = state_q;
		addr_d     = addr_q;
		rd_addr_d  = rd_addr_q;
		rd_vld_d   = 1'b0;
		rs_end_d   = rs_end_q;
		resolved_d = resolved_q;
		init_d     = init_q;
		best_d     = best_q;
		best_idx_d = best_idx_q;
		cmd_d      = cmd_q;

		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_data = '0;
		v_we     = 1'b0;
		v_waddr  = addr_q;
		v_wdata  = '0;
		v_raddr  = addr_q;
		m_we     = 1'b0;
		m_waddr  = rd_addr_q[VAB-1:TB];
		m_wdata  = TW'(cur_idx);
		m_raddr  = cmd.label[RB-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd.kind)
						mtlc_pkg::OP_VOTE: begin
							cmd_pop = 1'b1;
							v_raddr = {cmd.label[RB-1:0], cmd.tissue[TB-1:0]};
							addr_d  = {cmd.label[RB-1:0], cmd.tissue[TB-1:0]};
							state_d = ST_VOTE;
						end
						mtlc_pkg::OP_APPLY: begin
							if (!res_full) begin
								cmd_pop = 1'b1;
								if (cmd.hit) begin
									cmd_d   = cmd;
									state_d = ST_APPLY;
								end else begin
									res_push       = 1'b1;
									res_data.label = cmd.label;
								end
							end
						end
						mtlc_pkg::OP_RESOLVE: begin
							cmd_pop  = 1'b1;
							addr_d   = '0;
							rs_end_d = 1'b0;
							state_d  = ST_RESOLVE;
						end
						mtlc_pkg::OP_CLEAR: begin
							cmd_pop = 1'b1;
							addr_d  = '0;
							state_d = ST_CLEAR;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_VOTE: begin
				// counter saturates at all ones
				v_we    = 1'b1;
				v_wdata = (&v_rdata) ? v_rdata : v_rdata + VOTE_BITS'(1);
				state_d = ST_IDLE;
			end
			ST_APPLY: begin
				res_push        = 1'b1;
				res_data.erased = mismatch;
				res_data.label  = mismatch ? '0 : cmd_q.label;
				state_d         = ST_IDLE;
			end
			ST_RESOLVE: begin
				if (!rs_end_q) begin
					rd_vld_d  = 1'b1;
					rd_addr_d = addr_q;
					addr_d    = addr_q + VAB'(1);
					if (addr_q == VAB'(VDEPTH - 1)) begin
						rs_end_d = 1'b1;
					end
				end
				if (rd_vld_q) begin
					best_d     = cur_best;
					best_idx_d = cur_idx;
					m_we       = (rd_t == '1);
				end else if (rs_end_q) begin
					rs_end_d   = 1'b0;
					resolved_d = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				v_we   = 1'b1;
				addr_d = addr_q + VAB'(1);
				if (addr_q == VAB'(VDEPTH - 1)) begin
					init_d  = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			addr_q     <= '0;
			rd_vld_q   <= 1'b0;
			rs_end_q   <= 1'b0;
			resolved_q <= 1'b0;
			init_q     <= 1'b1;
		end else begin
			state_q    <= state_d;
			addr_q     <= addr_d;
			rd_vld_q   <= rd_vld_d;
			rs_end_q   <= rs_end_d;
			resolved_q <= resolved_d;
			init_q     <= init_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q  <= rd_addr_d;
		best_q     <= best_d;
		best_idx_q <= best_idx_d;
		cmd_q      <= cmd_d;
	end

	assign init_busy = init_q;

endmodule

`default_nettype wire

### src/majority_tissue_label_cleanup.sv
// Voxel label cleanup against a tissue majority per atlas region. Items enter
// through a push/full queue port and apply results leave through an empty/pop
// queue port. A two-word command queue parts the front, which classifies words and
// drops background or out-of-table votes, from the back, which owns a simple
// dual-port vote memory of min(REGION_LABELS,256) x 2^clog2(min(TISSUE_CLASSES,8))
// counters and a majority memory of one entry per region. A vote is a
// read-modify-write of its counter in the vote memory, an apply reads the
// majority memory (background or out-of-table labels are answered straight
// from idle), a resolve scans every counter and a clear sweeps every counter.
// After reset the clearing sweep holds full high; 2048 counters at default size.
`default_nettype none

module majority_tissue_label_cleanup #(
	parameter int REGION_LABELS  = 256,
	parameter int TISSUE_CLASSES = 8,
	parameter int VOTE_BITS      = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mtlc_pkg::item_t   item,
	input  wire logic              push,
	output logic                   full,
	output mtlc_pkg::result_t      result,
	output logic                   empty,
	input  wire logic              pop
);

	localparam int CMD_W = $bits(mtlc_pkg::cmd_t);
	localparam int RES_W = $bits(mtlc_pkg::result_t);

	mtlc_pkg::cmd_t    front_cmd;
	mtlc_pkg::cmd_t    back_cmd;
	mtlc_pkg::result_t res_data;
	logic [CMD_W-1:0]  back_cmd_bits;
	logic [RES_W-1:0]  result_bits;
	logic              cmd_push;
	logic              cmd_full;
	logic              cmd_pop;
	logic              cmd_empty;
	logic              res_push;
	logic              res_full;
	logic              init_busy;

	mtlc_front #(
		.REGION_LABELS (REGION_LABELS),
		.TISSUE_CLASSES(TISSUE_CLASSES)
	) u_front (
		.item     (item),
		.push     (push),
		.full     (full),
		.init_busy(init_busy),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (front_cmd)
	);

	mtlc_fifo #(
		.WIDTH(CMD_W)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (front_cmd),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (back_cmd_bits),
		.empty (cmd_empty)
	);

	assign back_cmd = mtlc_pkg::cmd_t'(back_cmd_bits);

	mtlc_back #(
		.REGION_LABELS (REGION_LABELS),
		.TISSUE_CLASSES(TISSUE_CLASSES),
		.VOTE_BITS     (VOTE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (back_cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data),
		.init_busy(init_busy)
	);

	mtlc_fifo #(
		.WIDTH(RES_W)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_data),
		.full  (res_full),
		.pop   (pop),
		.rdata (result_bits),
		.empty (empty)
	);

	assign result = mtlc_pkg::result_t'(result_bits);

	// the back only starts an apply with room for its word
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result word pushed into a full queue");

	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command taken from an empty queue");

	a_result_from_back: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(res_push))
		else $error("result appeared without a push from the back");

	a_no_entry_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !cmd_push)
		else $error("command entered during the clearing sweep");

endmodule

`default_nettype wire
